FILE: design/bdp_pkg.sv
// shared constants, mode codes and counter helper for the branch direction predictor
package bdp_pkg;

   // field widths
   localparam int PC_W    = 32;
   localparam int MODE_W  = 3;
   localparam int CTR_W   = 2;
   localparam int CNT_W   = 32;
   localparam int STALL_W = 2;

   // word address width: branch_pc without its two low bits
   localparam int WORD_W = PC_W - 2;

   // default pattern table depth
   localparam int TABLE_ENTRIES_DEFAULT = 1024;

   // predictor modes
   localparam logic [MODE_W-1:0] MODE_NOT_TAKEN = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TAKEN     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_COUNTER   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BIMODAL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_GSHARE    = 3'd4;

   // stall reported per beat
   localparam logic [STALL_W-1:0] STALL_HIT  = 2'd0;
   localparam logic [STALL_W-1:0] STALL_MISS = 2'd2;

   // saturating counter limits
   localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
   localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;

   // 2-bit saturating counter step
   function automatic logic [CTR_W-1:0] counter_next(input logic [CTR_W-1:0] c,
                                                     input logic t);
      logic [CTR_W-1:0] n;
      if (t) begin
         n = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
      end else begin
         n = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
      end
      return n;
   endfunction

endpackage

FILE: design/branch_direction_predictor.sv
// branch direction predictor top level: control, history, counters and result register
//
// One resolved branch per input beat; one result beat per branch giving the
// prediction made from the state before the branch, the stall (0 hit, 2 miss)
// and the running hit and miss totals. After reset the block sweeps the
// pattern table to zero, one entry per cycle, through every entry before
// req_ready first rises; csr writes are taken during the sweep. The static and
// single-counter modes step through accept and update for each branch. The
// bimodal and gshare modes read, modify and write back one table entry, with
// an index step between accept and update; when TABLE_ENTRIES is not a power
// of two the index is reduced modulo the depth by a reciprocal multiply
// pipelined through quotient, product and remainder stages. A new branch
// is accepted while the previous result still waits on rsp_ready; only the
// update step waits for the result register.
module branch_direction_predictor #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic [bdp_pkg::MODE_W-1:0]  csr_predictor_mode,
   // resolved branch
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bdp_pkg::PC_W-1:0]    req_branch_pc,
   input  logic                        req_taken,
   // prediction result
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_predicted_taken,
   output logic [bdp_pkg::STALL_W-1:0] rsp_stall_cycles,
   output logic [bdp_pkg::CNT_W-1:0]   rsp_hit_total,
   output logic [bdp_pkg::CNT_W-1:0]   rsp_miss_total
);
   import bdp_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int HIST_W = IDX_W;
   localparam int CLR_W  = IDX_W + 1;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_INDEX,
      S_UPDATE
   } state_type;

   state_type          state_ff,    state_in;
   logic [CLR_W-1:0]   clr_cnt_ff,  clr_cnt_in;
   logic [MODE_W-1:0]  mode_ff,     mode_in;
   logic               taken_ff,    taken_in;
   logic [CTR_W-1:0]   gctr_ff,     gctr_in;
   logic [HIST_W-1:0]  hist_ff,     hist_in;
   logic [CNT_W-1:0]   hit_ff,      hit_in;
   logic [CNT_W-1:0]   miss_ff,     miss_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_pred_ff,  rsp_pred_in;
   logic [STALL_W-1:0] rsp_stall_ff, rsp_stall_in;

   logic               accept;
   logic               out_free;
   logic               table_mode;
   logic [WORD_W-1:0]  hash_word;
   logic               idx_start;
   logic               idx_done;
   logic [IDX_W-1:0]   idx;
   logic [CTR_W-1:0]   pht_rd_data;
   logic               pht_wr_en;
   logic [IDX_W-1:0]   pht_wr_addr;
   logic [CTR_W-1:0]   pht_wr_data;
   logic               pred;
   logic [HIST_W:0]    hist_shift;

   // index reduction
   bdp_index #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_index (
      .clock (clock),
      .reset (reset),
      .start (idx_start),
      .word  (hash_word),
      .done  (idx_done),
      .idx   (idx)
   );

   // pattern table
   bdp_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (idx_done),
      .rd_addr (idx),
      .rd_data (pht_rd_data),
      .wr_en   (pht_wr_en),
      .wr_addr (pht_wr_addr),
      .wr_data (pht_wr_data)
   );

   // handshake and hashed index source
   always_comb begin
      accept     = req_valid && (state_ff == S_IDLE);
      out_free   = !rsp_valid_ff || rsp_ready;
      table_mode = (mode_ff == MODE_BIMODAL) || (mode_ff == MODE_GSHARE);
      hash_word  = req_branch_pc[PC_W-1:2];
      if (mode_ff == MODE_GSHARE) begin
         hash_word = req_branch_pc[PC_W-1:2] ^ WORD_W'(hist_ff);
      end
      idx_start  = accept && table_mode;
      hist_shift = {hist_ff, taken_ff};
   end

   // sequencer, predictor state and result register
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      mode_in      = csr_wr_en ? csr_predictor_mode : mode_ff;
      taken_in     = accept ? req_taken : taken_ff;
      gctr_in      = gctr_ff;
      hist_in      = hist_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pred_in  = rsp_pred_ff;
      rsp_stall_in = rsp_stall_ff;
      pht_wr_en    = 1'b0;
      pht_wr_addr  = idx;
      pht_wr_data  = counter_next(pht_rd_data, taken_ff);
      pred         = 1'b0;

      // prediction from the state as it stood before this branch
      case (mode_ff) inside
         MODE_TAKEN:                 pred = 1'b1;
         MODE_COUNTER:               pred = gctr_ff[CTR_W-1];
         MODE_BIMODAL, MODE_GSHARE:  pred = pht_rd_data[CTR_W-1];
         default:                    pred = 1'b0;
      endcase

      unique case (state_ff)
         S_CLEAR: begin
            pht_wr_en   = 1'b1;
            pht_wr_addr = clr_cnt_ff[IDX_W-1:0];
            pht_wr_data = CTR_MIN;
            clr_cnt_in  = clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = table_mode ? S_INDEX : S_UPDATE;
            end
         end
         S_INDEX: begin
            // table read issues when the index lands
            if (idx_done) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_pred_in  = pred;
               if (pred == taken_ff) begin
                  hit_in       = hit_ff + CNT_W'(1);
                  rsp_stall_in = STALL_HIT;
               end else begin
                  miss_in      = miss_ff + CNT_W'(1);
                  rsp_stall_in = STALL_MISS;
               end
               case (mode_ff) inside
                  MODE_COUNTER: gctr_in = counter_next(gctr_ff, taken_ff);
                  MODE_BIMODAL: pht_wr_en = 1'b1;
                  MODE_GSHARE: begin
                     pht_wr_en = 1'b1;
                     hist_in   = hist_shift[HIST_W-1:0];
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         mode_ff      <= MODE_NOT_TAKEN;
         gctr_ff      <= CTR_MIN;
         hist_ff      <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         mode_ff      <= mode_in;
         gctr_ff      <= gctr_in;
         hist_ff      <= hist_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      taken_ff     <= taken_in;
      rsp_pred_ff  <= rsp_pred_in;
      rsp_stall_ff <= rsp_stall_in;
   end

   // totals change only as a new result beat is loaded, so they ride with it
   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = rsp_pred_ff;
   assign rsp_stall_cycles    = rsp_stall_ff;
   assign rsp_hit_total       = hit_ff;
   assign rsp_miss_total      = miss_ff;

`ifndef ASSERT_OFF
   // a new result beat appears only out of the update step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_UPDATE))
      else $error("result beat raised outside the update step");

   // every finished branch counts exactly one hit or one miss
   a_one_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE && out_free) |=>
         (CNT_W'(hit_ff + miss_ff) == CNT_W'($past(hit_ff) + $past(miss_ff) + CNT_W'(1))))
      else $error("hit and miss totals did not advance by one");

   // the index unit answers only while the sequencer waits for it
   a_idx_when_waiting: assert property (@(posedge clock) disable iff (reset)
      idx_done |-> (state_ff == S_INDEX))
      else $error("index ready outside the index step");

   // no table write from an update while the result slot is occupied
   a_no_write_stalled: assert property (@(posedge clock) disable iff (reset)
      (pht_wr_en && state_ff == S_UPDATE) |-> out_free)
      else $error("table written while the result register is full");
`endif

endmodule

FILE: design/bdp_index.sv
// pattern table index unit: reduces the hashed word address modulo the table depth
module bdp_index #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [bdp_pkg::WORD_W-1:0] word,
   output logic                      done,
   output logic [IDX_W-1:0]          idx
);
   import bdp_pkg::*;

   localparam bit POW2 = (TABLE_ENTRIES == (1 << IDX_W));

   generate
      if (POW2) begin : g_mask
         logic             done_ff;
         logic [IDX_W-1:0] idx_ff;

         // power-of-two depth: the index is the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            if (start) begin
               idx_ff <= word[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end else begin : g_recip
         localparam int MUL_S  = WORD_W + IDX_W;
         localparam int PROD_W = 2 * WORD_W + 1;
         localparam int Q_W    = PROD_W - MUL_S;
         localparam logic [WORD_W:0] RECIP =
            (WORD_W+1)'((64'd1 << MUL_S) / 64'(TABLE_ENTRIES));
         localparam logic [IDX_W:0] DEPTH = (IDX_W+1)'(TABLE_ENTRIES);

         logic                stage1_ff;
         logic                stage2_ff;
         logic                stage3_ff;
         logic                done_ff;
         logic [WORD_W-1:0]   word_ff;
         logic [Q_W-1:0]      quot_ff;
         logic [WORD_W:0]     back_ff;
         logic [IDX_W-1:0]    idx_ff;
         logic [PROD_W-1:0]   recip_prod;
         logic [Q_W+IDX_W:0]  quot_prod;
         logic [WORD_W:0]     rem_raw;
         logic [IDX_W:0]      rem_fix;

         // quotient estimate by reciprocal multiply, at most one short of the true one,
         // so one compare and subtract lands the remainder in range
         always_comb begin
            recip_prod = word_ff * RECIP;
            quot_prod  = quot_ff * DEPTH;
            rem_raw    = {1'b0, word_ff} - back_ff;
            rem_fix    = (rem_raw[IDX_W:0] >= DEPTH) ? rem_raw[IDX_W:0] - DEPTH
                                                     : rem_raw[IDX_W:0];
         end

         // three stages: quotient, quotient times depth, corrected remainder
         always_ff @(posedge clock) begin
            if (reset) begin
               stage1_ff <= 1'b0;
               stage2_ff <= 1'b0;
               stage3_ff <= 1'b0;
               done_ff   <= 1'b0;
            end else begin
               stage1_ff <= start;
               stage2_ff <= stage1_ff;
               stage3_ff <= stage2_ff;
               done_ff   <= stage3_ff;
            end
            if (start) begin
               word_ff <= word;
            end
            if (stage1_ff) begin
               quot_ff <= recip_prod[PROD_W-1:MUL_S];
            end
            if (stage2_ff) begin
               back_ff <= quot_prod[WORD_W:0];
            end
            if (stage3_ff) begin
               idx_ff <= rem_fix[IDX_W-1:0];
            end
         end

         assign done = done_ff;
         assign idx  = idx_ff;
      end
   endgenerate

endmodule

FILE: design/bdp_table.sv
// pattern history table: one write port, one registered read port
module bdp_table #(
   parameter int TABLE_ENTRIES = bdp_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [bdp_pkg::CTR_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [bdp_pkg::CTR_W-1:0] wr_data
);
   import bdp_pkg::*;

   logic [CTR_W-1:0] mem [TABLE_ENTRIES];
   logic [CTR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the branch direction predictor
`timescale 1ns / 1ps

module testbench;
   import bdp_pkg::*;

   // model geometry follows the block's default table depth
   localparam int TABLE_DEPTH = TABLE_ENTRIES_DEFAULT;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEG_ITEMS   = 55;
   localparam int SEGS        = 5;
   localparam int POOL_SIZE   = 16;

   // mode codes the block treats as static not-taken
   localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;

   typedef struct packed {
      logic               predicted;
      logic [STALL_W-1:0] stall;
      logic [CNT_W-1:0]   hits;
      logic [CNT_W-1:0]   misses;
   } branch_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [MODE_W-1:0]   csr_predictor_mode = MODE_NOT_TAKEN;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [PC_W-1:0]     req_branch_pc = '0;
   logic                req_taken = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_predicted_taken;
   logic [STALL_W-1:0]  rsp_stall_cycles;
   logic [CNT_W-1:0]    rsp_hit_total;
   logic [CNT_W-1:0]    rsp_miss_total;

   // predictor copy kept in step with every accepted beat
   logic [MODE_W-1:0]   model_mode;
   logic [CTR_W-1:0]    model_counter;
   logic [CTR_W-1:0]    model_pattern [TABLE_DEPTH];
   logic [IDX_W-1:0]    model_history;
   logic [CNT_W-1:0]    model_hits;
   logic [CNT_W-1:0]    model_misses;

   branch_result_type   pending_predictions[$];

   int                  tx_idle_pct = 32;
   int                  rx_idle_pct = 73;
   int                  error_count = 0;
   int                  branches_sent = 0;
   int                  results_checked = 0;
   int                  mode_writes = 0;
   int                  cycle_count = 0;

   branch_direction_predictor DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_predictor_mode  (csr_predictor_mode),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_branch_pc       (req_branch_pc),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_stall_cycles    (rsp_stall_cycles),
      .rsp_hit_total       (rsp_hit_total),
      .rsp_miss_total      (rsp_miss_total)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_predictions.size());
         $display("tb: failure");
         $finish;
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // 2-bit saturating counter step
   function automatic logic [CTR_W-1:0] saturate_step(input logic [CTR_W-1:0] c,
                                                      input logic tk);
      logic [CTR_W-1:0] n;
      n = c;
      if (tk && c != 2'd3) n = c + 2'd1;
      if (!tk && c != 2'd0) n = c - 2'd1;
      return n;
   endfunction

   function automatic void clear_model();
      model_mode    = MODE_NOT_TAKEN;
      model_counter = '0;
      model_history = '0;
      model_hits    = '0;
      model_misses  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) model_pattern[i] = '0;
   endfunction

   // predict from the state before the branch, then train on its outcome
   function automatic branch_result_type predict_branch(input logic [PC_W-1:0] pc,
                                                        input logic tk);
      branch_result_type r;
      logic [IDX_W-1:0]  idx;
      logic              guess;
      guess = 1'b0;
      idx   = pc[IDX_W+1:2];
      case (model_mode)
         MODE_TAKEN: begin
            guess = 1'b1;
         end
         MODE_COUNTER: begin
            guess         = model_counter[1];
            model_counter = saturate_step(model_counter, tk);
         end
         MODE_BIMODAL: begin
            guess              = model_pattern[idx][1];
            model_pattern[idx] = saturate_step(model_pattern[idx], tk);
         end
         MODE_GSHARE: begin
            idx                = idx ^ model_history;
            guess              = model_pattern[idx][1];
            model_pattern[idx] = saturate_step(model_pattern[idx], tk);
            model_history      = {model_history[IDX_W-2:0], tk};
         end
         default: begin
            guess = 1'b0;
         end
      endcase
      if (guess == tk) model_hits = model_hits + 1'b1;
      else model_misses = model_misses + 1'b1;
      r.predicted = guess;
      r.stall     = (guess == tk) ? STALL_HIT : STALL_MISS;
      r.hits      = model_hits;
      r.misses    = model_misses;
      return r;
   endfunction

   function automatic void report_mismatch(input string field, input logic [CNT_W-1:0] want,
                                           input logic [CNT_W-1:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch at %0t on %s: expected %0h, got %0h", $realtime, field, want, got);
   endfunction

   // result beat checker
   always @(posedge clock) begin : check_result
      branch_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_predictions.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("mismatch at %0t: result beat with nothing outstanding", $realtime);
         end else begin
            want = pending_predictions.pop_front();
            results_checked++;
            if (rsp_predicted_taken !== want.predicted)
               report_mismatch("predicted_taken", want.predicted, rsp_predicted_taken);
            if (rsp_stall_cycles !== want.stall)
               report_mismatch("stall_cycles", want.stall, rsp_stall_cycles);
            if (rsp_hit_total !== want.hits)
               report_mismatch("hit_total", want.hits, rsp_hit_total);
            if (rsp_miss_total !== want.misses)
               report_mismatch("miss_total", want.misses, rsp_miss_total);
         end
      end
   end

   // one branch beat; called and returns at a falling edge, valid left high
   task automatic send_branch(input logic [PC_W-1:0] pc, input logic tk);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_branch_pc = pc;
      req_taken     = tk;
      do @(posedge clock); while (!req_ready);
      pending_predictions.push_back(predict_branch(pc, tk));
      branches_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every outstanding result has come back
   task automatic wait_for_results();
      req_valid = 1'b0;
      while (pending_predictions.size() != 0) @(negedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] m);
      wait_for_results();
      csr_wr_en          = 1'b1;
      csr_predictor_mode = m;
      @(negedge clock);
      csr_wr_en  = 1'b0;
      model_mode = m;
      mode_writes++;
   endtask

   // static modes and two of the reserved codes, with extreme addresses
   task automatic test_static_modes();
      write_mode(MODE_NOT_TAKEN);
      send_branch(32'h0000_0000, 1'b1);
      send_branch(32'hFFFF_FFFF, 1'b0);
      write_mode(MODE_TAKEN);
      send_branch(32'hFFFF_FFFF, 1'b1);
      send_branch(32'h0000_0000, 1'b0);
      write_mode(MODE_RSVD_HI);
      send_branch(32'h8000_0000, 1'b1);
      write_mode(MODE_RSVD_LO);
      send_branch(32'h7FFF_FFFC, 1'b0);
   endtask

   // single counter up to saturation and back down to its floor at zero
   task automatic test_counter_mode();
      write_mode(MODE_COUNTER);
      repeat (4) send_branch($urandom, 1'b1);
      repeat (4) send_branch($urandom, 1'b0);
   endtask

   // bimodal training, aliasing of the index and the top table entry
   task automatic test_bimodal_mode();
      write_mode(MODE_BIMODAL);
      send_branch(32'h0000_0004, 1'b1);
      send_branch(32'h0000_0004, 1'b1);
      send_branch(32'h0000_1004, 1'b0);
      send_branch(32'hFFFF_FFFC, 1'b1);
      send_branch(32'h0000_0FFF, 1'b1);
   endtask

   // gshare shares the trained table, history shifts per branch
   task automatic test_gshare_mode();
      write_mode(MODE_GSHARE);
      send_branch(32'h0000_0004, 1'b1);
      send_branch(32'h0000_0004, 1'b1);
      send_branch(32'h0000_0004, 1'b0);
      send_branch(32'hFFFF_FFFC, 1'b1);
      send_branch(32'h0000_0FFC, 1'b0);
   endtask

   // loop-like branches with biased outcomes mixed with random noise
   task automatic test_random_traffic();
      logic [MODE_W-1:0] mode_plan [15];
      logic [PC_W-1:0]   pool_pc [POOL_SIZE];
      int                pool_bias [POOL_SIZE];
      int                pick;
      mode_plan = '{MODE_GSHARE, MODE_BIMODAL, MODE_COUNTER, MODE_GSHARE, MODE_TAKEN,
                    MODE_BIMODAL, MODE_RSVD_HI, MODE_GSHARE, MODE_NOT_TAKEN, MODE_BIMODAL,
                    MODE_COUNTER, MODE_GSHARE, MODE_RSVD_MID, MODE_BIMODAL, MODE_GSHARE};
      for (int phase = 0; phase < 3; phase++) begin
         wait_for_results();
         case (phase)
            0: begin tx_idle_pct = 32; rx_idle_pct = 73; end
            1: begin tx_idle_pct = 73; rx_idle_pct = 32; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < SEGS; seg++) begin
            write_mode(mode_plan[phase * SEGS + seg]);
            for (int i = 0; i < POOL_SIZE; i++) begin
               pool_pc[i]   = ($urandom_range(0, 1) != 0) ? $urandom
                                 : {20'h0, 12'($urandom_range(0, 4095))};
               pool_bias[i] = $urandom_range(0, 100);
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
               if ($urandom_range(0, 59) == 0) wait_for_results();
               if ($urandom_range(0, 9) < 7) begin
                  pick = $urandom_range(0, POOL_SIZE - 1);
                  send_branch(pool_pc[pick], $urandom_range(0, 99) < pool_bias[pick]);
               end else begin
                  send_branch($urandom, 1'($urandom_range(0, 1)));
               end
            end
         end
      end
   endtask

   initial begin
      clear_model();
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_static_modes();
      test_counter_mode();
      test_bimodal_mode();
      test_gshare_mode();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(negedge clock);
      $display("summary: %0d branches over %0d mode writes (all eight mode codes),",
               branches_sent, mode_writes);
      $display("summary: %0d result beats checked under three idling profiles",
               results_checked);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", error_count);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
